>>> src/lifnu_pkg.sv
// Package for the fixed-point LIF neuron update block.
// Holds sizes, neuron model codes, register indexes and the configuration struct.
// Used by lifnu_cfg and fixed_point_lif_neuron_update.
package lifnu_pkg;

  localparam int NEURONS = 1024;
  localparam int IDX_W   = $clog2(NEURONS);
  localparam int DATA_W  = 32;
  localparam int DECAY_W = 16;
  localparam int SHIFT_W = 5;
  localparam int PROD_W  = DATA_W + DECAY_W;
  localparam int CFG_IDX_W = 3;

  // Neuron model codes
  localparam logic [1:0] MODEL_LIF     = 2'd0;
  localparam logic [1:0] MODEL_LI      = 2'd1;
  localparam logic [1:0] MODEL_CUBA    = 2'd2;
  localparam logic [1:0] MODEL_CUBA_LI = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODEL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CUR_DECAY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOL_DECAY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_V   = 3'd5;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;

  typedef struct packed {
    logic [1:0]                neuron_model;
    logic signed [DECAY_W-1:0] current_decay;
    logic signed [DECAY_W-1:0] voltage_decay;
    logic [SHIFT_W-1:0]        decay_shift;
    logic signed [DATA_W-1:0]  fire_threshold;
    logic signed [DATA_W-1:0]  reset_voltage;
  } cfg_t;

endpackage

>>> src/fixed_point_lif_neuron_update.sv
// Top level of the fixed-point LIF neuron update block: state memories,
// sequencer and datapath. Depends on lifnu_pkg and lifnu_cfg.
//
//   channel | handshake                   | payload
//   --------+-----------------------------+----------------------------------------
//   in      | in_valid_i / in_stall_o     | neuron_index_i, synaptic_input_i
//   out     | out_valid_o / out_stall_i   | neuron_out_index_o, spike_o, membrane_out_o
//   cfg     | cfg_valid_i / cfg_ready_o   | cfg_index_i, cfg_data_i
//
// The memory read happens at the input transfer; the result then passes through
// multiply, shift and current add, voltage add and compare, and write back, where it
// loads into the output register. The sequencer holds one item at a time and takes
// the next item only after write back, once it is back in idle.
// After reset a clearing pass zeroes all 1024 entries of both memories, one entry a cycle;
// input stays stalled meanwhile, configuration writes are taken at all times.
// A stalled result holds in the output register; write back waits for it to drain.
module fixed_point_lif_neuron_update (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [lifnu_pkg::IDX_W-1:0]     neuron_index_i,
  input  logic signed [lifnu_pkg::DATA_W-1:0] synaptic_input_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [lifnu_pkg::IDX_W-1:0]     neuron_out_index_o,
  output logic                            spike_o,
  output logic signed [lifnu_pkg::DATA_W-1:0] membrane_out_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lifnu_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lifnu_pkg::DATA_W-1:0]    cfg_data_i
);

  localparam int IDX_W  = lifnu_pkg::IDX_W;
  localparam int DATA_W = lifnu_pkg::DATA_W;
  localparam int PROD_W = lifnu_pkg::PROD_W;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_SHIFT = 3'd3;
  localparam logic [2:0] ST_SUM   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(lifnu_pkg::NEURONS - 1);

  lifnu_pkg::cfg_t cfg;

  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] clr_addr_q, clr_addr_d;

  logic [DATA_W-1:0] cur_mem [lifnu_pkg::NEURONS];
  logic [DATA_W-1:0] vol_mem [lifnu_pkg::NEURONS];

  logic                     in_xfer;
  logic                     done_fire;
  logic [IDX_W-1:0]         idx_q;
  logic signed [DATA_W-1:0] syn_q;
  logic signed [DATA_W-1:0] cur_rd_q, vol_rd_q;
  logic signed [PROD_W-1:0] pc_q, pv_q, pc_d, pv_d, pc_sh, pv_sh;
  logic signed [DATA_W-1:0] cur_new_q, cur_new_d, vdec_q;
  logic signed [DATA_W-1:0] v_sum, v_fin_q, v_fin_d;
  logic                     spike_q, spike_d;
  logic                     cur_we, vol_we;
  logic [IDX_W-1:0]         wr_addr;
  logic [DATA_W-1:0]        cur_wdata, vol_wdata;
  logic                     out_valid_q;
  logic [IDX_W-1:0]         out_idx_q;
  logic                     out_spike_q;
  logic signed [DATA_W-1:0] out_mem_q;

  lifnu_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_valid_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign done_fire   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // Sequencer
  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    case (state_q)
      ST_CLEAR: begin
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == LAST_IDX) state_d = ST_IDLE;
      end
      ST_IDLE:  if (in_xfer) state_d = ST_MUL;
      ST_MUL:   state_d = ST_SHIFT;
      ST_SHIFT: state_d = ST_SUM;
      ST_SUM:   state_d = ST_DONE;
      ST_DONE:  if (done_fire) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // Read both state words on input transfer; capture the item
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cur_rd_q <= cur_mem[neuron_index_i];
      vol_rd_q <= vol_mem[neuron_index_i];
      idx_q    <= neuron_index_i;
      syn_q    <= synaptic_input_i;
    end
  end

  // Decay products
  assign pc_d = cfg.current_decay * cur_rd_q;
  assign pv_d = cfg.voltage_decay * vol_rd_q;

  // Arithmetic shift, then new current
  assign pc_sh     = pc_q >>> cfg.decay_shift;
  assign pv_sh     = pv_q >>> cfg.decay_shift;
  assign cur_new_d = cfg.neuron_model[1] ? (pc_sh[DATA_W-1:0] + syn_q) : cur_rd_q;

  // Voltage sum, threshold and reset
  always_comb begin
    v_sum   = vdec_q + (cfg.neuron_model[1] ? cur_new_q : syn_q);
    v_fin_d = v_sum;
    spike_d = 1'b0;
    case (cfg.neuron_model)
      lifnu_pkg::MODEL_LIF: begin
        if (v_sum > cfg.fire_threshold) begin
          spike_d = 1'b1;
          v_fin_d = cfg.reset_voltage;
        end
      end
      lifnu_pkg::MODEL_CUBA: begin
        if (v_sum > cfg.fire_threshold) begin
          spike_d = 1'b1;
          v_fin_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      pc_q <= pc_d;
      pv_q <= pv_d;
    end
    if (state_q == ST_SHIFT) begin
      cur_new_q <= cur_new_d;
      vdec_q    <= pv_sh[DATA_W-1:0];
    end
    if (state_q == ST_SUM) begin
      v_fin_q <= v_fin_d;
      spike_q <= spike_d;
    end
  end

  // Memory write: zero sweep after reset, else write back on completion
  always_comb begin
    if (state_q == ST_CLEAR) begin
      cur_we    = 1'b1;
      vol_we    = 1'b1;
      wr_addr   = clr_addr_q;
      cur_wdata = '0;
      vol_wdata = '0;
    end else begin
      cur_we    = done_fire;
      vol_we    = done_fire;
      wr_addr   = idx_q;
      cur_wdata = cur_new_q;
      vol_wdata = v_fin_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cur_we) cur_mem[wr_addr] <= cur_wdata;
    if (vol_we) vol_mem[wr_addr] <= vol_wdata;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_fire) begin
      out_idx_q   <= idx_q;
      out_spike_q <= spike_q;
      out_mem_q   <= v_fin_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign neuron_out_index_o = out_idx_q;
  assign spike_o            = out_spike_q;
  assign membrane_out_o     = out_mem_q;

endmodule

>>> src/lifnu_cfg.sv
// Configuration register file for the LIF neuron update block.
// Depends on lifnu_pkg for register indexes and the cfg_t struct.
module lifnu_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           we_i,
  input  logic [lifnu_pkg::CFG_IDX_W-1:0] index_i,
  input  logic [lifnu_pkg::DATA_W-1:0]   data_i,
  output lifnu_pkg::cfg_t                cfg_o
);

  lifnu_pkg::cfg_t cfg_q, cfg_d;

  // Decode the write; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (index_i)
        lifnu_pkg::REG_MODEL:     cfg_d.neuron_model   = data_i[1:0];
        lifnu_pkg::REG_CUR_DECAY: cfg_d.current_decay  = data_i[lifnu_pkg::DECAY_W-1:0];
        lifnu_pkg::REG_VOL_DECAY: cfg_d.voltage_decay  = data_i[lifnu_pkg::DECAY_W-1:0];
        lifnu_pkg::REG_SHIFT:     cfg_d.decay_shift    = data_i[lifnu_pkg::SHIFT_W-1:0];
        lifnu_pkg::REG_THRESHOLD: cfg_d.fire_threshold = data_i;
        lifnu_pkg::REG_RESET_V:   cfg_d.reset_voltage  = data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.neuron_model   <= lifnu_pkg::MODEL_LIF;
      cfg_q.current_decay  <= '0;
      cfg_q.voltage_decay  <= '0;
      cfg_q.decay_shift    <= lifnu_pkg::SHIFT_RESET;
      cfg_q.fire_threshold <= '0;
      cfg_q.reset_voltage  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> bench/fixed_point_lif_neuron_update_test.sv
// Testbench for fixed_point_lif_neuron_update: directed and random neuron updates,
// checked against an in-bench prediction of per-neuron current and voltage.
// Depends on lifnu_pkg and the fixed_point_lif_neuron_update RTL.
module fixed_point_lif_neuron_update_test;
  import lifnu_pkg::*;

  localparam int unsigned ITEMS      = 1550;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned SETTLE     = 8;

  localparam logic signed [DATA_W-1:0] MAX_WORD = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] MIN_WORD = 32'sh8000_0000;

  localparam logic signed [DECAY_W-1:0] UNITY_DECAY = 16'sd4096;
  localparam logic signed [DECAY_W-1:0] MAX_DECAY   = 16'sh7FFF;
  localparam logic signed [DECAY_W-1:0] MIN_DECAY   = 16'sh8000;

  localparam logic [IDX_W-1:0] LAST_NEURON = IDX_W'(NEURONS - 1);

  // Indexes past the last register: writes to these must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef struct {
    logic [IDX_W-1:0]         index;
    logic                     spike;
    logic signed [DATA_W-1:0] membrane;
  } neuron_result_t;

  // Track neuron state and registers; queue the result of each accepted update
  class neuron_scoreboard;
    cfg_t                     cfg;
    logic signed [DATA_W-1:0] current_mem [NEURONS];
    logic signed [DATA_W-1:0] voltage_mem [NEURONS];
    neuron_result_t           expected_updates [$];
    int unsigned              mismatches;

    function new();
      cfg = '0;
      cfg.decay_shift = SHIFT_RESET;
      foreach (current_mem[i]) begin
        current_mem[i] = '0;
        voltage_mem[i] = '0;
      end
      mismatches = 0;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] index, logic [DATA_W-1:0] data);
      case (index)
        REG_MODEL:     cfg.neuron_model   = data[1:0];
        REG_CUR_DECAY: cfg.current_decay  = data[DECAY_W-1:0];
        REG_VOL_DECAY: cfg.voltage_decay  = data[DECAY_W-1:0];
        REG_SHIFT:     cfg.decay_shift    = data[SHIFT_W-1:0];
        REG_THRESHOLD: cfg.fire_threshold = data;
        REG_RESET_V:   cfg.reset_voltage  = data;
        default: ;
      endcase
    endfunction

    // Full signed product, arithmetic shift, keep the low word
    function logic signed [DATA_W-1:0] decay_scaled(logic signed [DECAY_W-1:0] factor,
                                                    logic signed [DATA_W-1:0] level);
      logic signed [PROD_W-1:0] product;
      product = factor * level;
      product = product >>> cfg.decay_shift;
      return product[DATA_W-1:0];
    endfunction

    function void note_update(logic [IDX_W-1:0] index, logic signed [DATA_W-1:0] stim);
      neuron_result_t           next;
      logic signed [DATA_W-1:0] cur;
      logic signed [DATA_W-1:0] volt;
      cur        = current_mem[index];
      volt       = voltage_mem[index];
      next.spike = 1'b0;
      if (cfg.neuron_model == MODEL_LIF || cfg.neuron_model == MODEL_LI) begin
        volt = decay_scaled(cfg.voltage_decay, volt) + stim;
        if (cfg.neuron_model == MODEL_LIF && volt > cfg.fire_threshold) begin
          next.spike = 1'b1;
          volt       = cfg.reset_voltage;
        end
      end else begin
        cur  = decay_scaled(cfg.current_decay, cur) + stim;
        volt = decay_scaled(cfg.voltage_decay, volt) + cur;
        if (cfg.neuron_model == MODEL_CUBA && volt > cfg.fire_threshold) begin
          next.spike = 1'b1;
          volt       = '0;
        end
      end
      current_mem[index] = cur;
      voltage_mem[index] = volt;
      next.index         = index;
      next.membrane      = volt;
      expected_updates.push_back(next);
    endfunction

    function void log_mismatch(string what, neuron_result_t want, neuron_result_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%s: want idx=%0d spike=%0d mem=%0d, got idx=%0d spike=%0d mem=%0d",
                 what, want.index, want.spike, want.membrane,
                 got.index, got.spike, got.membrane);
    endfunction

    function void check_result(logic [IDX_W-1:0] index, logic spike,
                               logic signed [DATA_W-1:0] membrane);
      neuron_result_t want;
      neuron_result_t got;
      got.index    = index;
      got.spike    = spike;
      got.membrane = membrane;
      if (expected_updates.size() == 0) begin
        want = '{default: 'x};
        log_mismatch("result with no update pending", want, got);
      end else begin
        want = expected_updates.pop_front();
        if (got.index !== want.index || got.spike !== want.spike ||
            got.membrane !== want.membrane)
          log_mismatch("neuron result mismatch", want, got);
      end
    endfunction

    function int unsigned outstanding();
      return expected_updates.size();
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [IDX_W-1:0]         neuron_index_i;
  logic signed [DATA_W-1:0] synaptic_input_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [IDX_W-1:0]         neuron_out_index_o;
  logic                     spike_o;
  logic signed [DATA_W-1:0] membrane_out_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i;
  logic [DATA_W-1:0]        cfg_data_i;

  neuron_scoreboard sb;
  bit               no_idle;
  int unsigned      items_sent;
  int unsigned      idle_cycles;
  logic [IDX_W-1:0] hot_base;

  fixed_point_lif_neuron_update u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .neuron_index_i     (neuron_index_i),
    .synaptic_input_i   (synaptic_input_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .neuron_out_index_o (neuron_out_index_o),
    .spike_o            (spike_o),
    .membrane_out_o     (membrane_out_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Observe every transfer at the clock edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        sb.check_result(neuron_out_index_o, spike_o, membrane_out_o);
      if (in_valid_i && !in_stall_o)
        sb.note_update(neuron_index_i, synaptic_input_i);
      if (cfg_valid_i && cfg_ready_o)
        sb.apply_reg(cfg_index_i, cfg_data_i);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic int unsigned pick_wait();
    return no_idle ? 0 : $urandom_range(0, 11);
  endfunction

  // Receiver: stall a random number of cycles, then take one result
  initial begin
    int unsigned hold;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = pick_wait();
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_item(input logic [IDX_W-1:0] index,
                           input logic signed [DATA_W-1:0] stim);
    int unsigned gap;
    gap = pick_wait();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    neuron_index_i   <= index;
    synaptic_input_i <= stim;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // Hold off input until every pending result has come back and the block is quiet
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] index, input logic [DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_neuron(input logic [1:0] model,
                                input logic signed [DECAY_W-1:0] cur_factor,
                                input logic signed [DECAY_W-1:0] volt_factor,
                                input logic [SHIFT_W-1:0] shift,
                                input logic signed [DATA_W-1:0] threshold,
                                input logic signed [DATA_W-1:0] reset_v);
    write_cfg(REG_MODEL, 32'(model));
    write_cfg(REG_CUR_DECAY, 32'(cur_factor));
    write_cfg(REG_VOL_DECAY, 32'(volt_factor));
    write_cfg(REG_SHIFT, 32'(shift));
    write_cfg(REG_THRESHOLD, threshold);
    write_cfg(REG_RESET_V, reset_v);
    // Poke an unused index; the settings above must survive it
    write_cfg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
  endtask

  function automatic logic signed [DECAY_W-1:0] pick_decay();
    case ($urandom_range(0, 7))
      0:       return 16'($urandom);
      1:       return MAX_DECAY;
      2:       return MIN_DECAY;
      3:       return '0;
      default: return 16'($urandom_range(1024, 4095));
    endcase
  endfunction

  function automatic logic [SHIFT_W-1:0] pick_shift();
    case ($urandom_range(0, 5))
      0:       return 5'($urandom);
      1:       return '0;
      2:       return '1;
      default: return SHIFT_RESET;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_threshold();
    case ($urandom_range(0, 7))
      0:       return $urandom;
      1:       return MAX_WORD;
      2:       return MIN_WORD;
      default: return $urandom_range(500, 20000);
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_reset_voltage();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return MIN_WORD;
      2:       return MAX_WORD;
      default: return $signed($urandom_range(0, 400)) - 200;
    endcase
  endfunction

  // Mostly a small group of neurons with moderate input, so state builds up and fires
  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(0, 4) == 0)
      return IDX_W'($urandom_range(0, NEURONS - 1));
    return hot_base + IDX_W'($urandom_range(0, 7));
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_input();
    case ($urandom_range(0, 11))
      0:       return $urandom;
      1:       return MAX_WORD;
      2:       return MIN_WORD;
      3:       return '1;
      default: return $signed($urandom_range(0, 8000)) - 3000;
    endcase
  endfunction

  initial begin
    sb          = new();
    in_valid_i       <= 1'b0;
    neuron_index_i   <= '0;
    synaptic_input_i <= '0;
    cfg_valid_i      <= 1'b0;
    cfg_index_i      <= '0;
    cfg_data_i       <= '0;
    no_idle     = 1'b0;
    items_sent  = 0;
    idle_cycles = 0;
    hot_base    = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // LIF: equal to threshold holds, one above fires, extremes wrap and reset
    program_neuron(MODEL_LIF, '0, UNITY_DECAY, SHIFT_RESET, 32'sd1000, -32'sd5);
    send_item(0, 0);
    send_item(5, 500);
    send_item(5, 500);
    send_item(5, 1);
    send_item(LAST_NEURON, MAX_WORD);
    send_item(LAST_NEURON, MIN_WORD);
    wait_for_results();

    // LI: no spike even past the lowest threshold, voltage wraps
    program_neuron(MODEL_LI, '0, UNITY_DECAY, SHIFT_RESET, MIN_WORD, MAX_WORD);
    send_item(9, MAX_WORD);
    send_item(9, 1);
    send_item(9, MIN_WORD);
    wait_for_results();

    // CUBA LIF: current builds, voltage crosses and resets to zero
    program_neuron(MODEL_CUBA, 16'sd2048, 16'sd3072, SHIFT_RESET, 32'sd100, MAX_WORD);
    send_item(3, 60);
    send_item(3, 60);
    send_item(3, MAX_WORD);
    send_item(3, 0);
    wait_for_results();

    // CUBA LI with extreme factors and no shift: product truncation
    program_neuron(MODEL_CUBA_LI, MIN_DECAY, MAX_DECAY, '0, MIN_WORD, MIN_WORD);
    send_item(3, MAX_WORD);
    send_item(3, MIN_WORD);
    send_item(3, '1);
    wait_for_results();

    // Largest shift with the most negative factor
    program_neuron(MODEL_LIF, MAX_DECAY, MIN_DECAY, '1, MIN_WORD, MAX_WORD);
    send_item(0, '1);
    send_item(0, MIN_WORD);
    wait_for_results();

    // Random phases, each under its own register setting
    while (items_sent < ITEMS) begin
      no_idle  = ($urandom_range(0, 3) == 0);
      hot_base = IDX_W'($urandom_range(0, NEURONS - 8));
      program_neuron(2'($urandom_range(0, 3)), pick_decay(), pick_decay(), pick_shift(),
                     pick_threshold(), pick_reset_voltage());
      repeat ($urandom_range(60, 200)) begin
        if ($urandom_range(0, 99) == 0)
          wait_for_results();
        send_item(pick_index(), pick_input());
      end
      wait_for_results();
    end

    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> files.f
src/lifnu_pkg.sv
src/lifnu_cfg.sv
src/fixed_point_lif_neuron_update.sv
bench/fixed_point_lif_neuron_update_test.sv
